@@ rtl/oil_paint_mode_filter_top_defines.svh @@
// Assertion macros for the oil paint mode filter RTL.
`ifndef OIL_PAINT_MODE_FILTER_TOP_DEFINES_SVH
`define OIL_PAINT_MODE_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OPMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("opmf assertion failed");
`define OPMF_NEVER(lbl, cond) \
  `OPMF_ASSERT(lbl, !(cond))
`else
`define OPMF_ASSERT(lbl, prop)
`define OPMF_NEVER(lbl, cond)
`endif
`endif

@@ rtl/opmf_pkg.sv @@
// Constants, types and the mod15 helper of the oil paint mode filter.
`default_nettype none
package opmf_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned MaxWindow  = 15;
  localparam int unsigned BinCount   = 256;
  localparam int unsigned ColW       = 10;
  localparam int unsigned RowW       = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned AddrW      = SlotW + ColW;
  localparam int unsigned StoreDepth = MaxWindow * MaxColumns;
  localparam int unsigned PixW       = 40;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CfgColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindow  = 2'd2;

  localparam logic [10:0] ColsReset = 11'd640;
  localparam logic [15:0] RowsReset = 16'd480;
  localparam logic [3:0]  WinReset  = 4'd3;

  typedef struct packed {
    logic accept;
    logic setup;
    logic issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic result_ready;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
    logic out_valid;
  } dp_sts_t;

  // x mod 15: 16 = 1 (mod 15), so sum the nibbles and fold once
  function automatic logic [SlotW-1:0] mod15(input logic [15:0] x);
    logic [5:0] s;
    logic [4:0] f;
    s = {2'b0, x[3:0]} + {2'b0, x[7:4]} + {2'b0, x[11:8]} + {2'b0, x[15:12]};
    f = {3'b0, s[5:4]} + {1'b0, s[3:0]};
    return (f >= 5'd15) ? 4'(f - 5'd15) : f[3:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/opmf_ctrl.sv @@
// Sequencer of the oil paint mode filter: input transfer, window scan, result.
`default_nettype none
`include "oil_paint_mode_filter_top_defines.svh"
module opmf_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire opmf_pkg::dp_sts_t    sts_i,
  output opmf_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCheck = 6'b000010,
    StSetup = 6'b000100,
    StScan  = 6'b001000,
    StFlush = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = StCheck;
      end
      StCheck: begin
        state_d = sts_i.result_ready ? StSetup : StIdle;
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StScan;
      end
      StScan: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) state_d = StFlush;
      end
      StFlush: begin
        // wait for the last window entry to leave the histogram stages
        if (!sts_i.pipe_busy) state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `OPMF_ASSERT(a_emit_loads_out, cmd_o.emit |=> sts_i.out_valid)
  `OPMF_ASSERT(a_idle_pipe_empty, (state_q == StIdle) |-> !sts_i.pipe_busy)
  `OPMF_ASSERT(a_setup_after_ready, (state_q == StSetup) |-> $past(sts_i.result_ready))

endmodule
`default_nettype wire

@@ rtl/opmf_dp.sv @@
// Datapath: config, line store, position counters, histogram scan, output register.
`default_nettype none
module opmf_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire opmf_pkg::ctrl_cmd_t               cmd_i,
  output opmf_pkg::dp_sts_t                      sts_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [opmf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [opmf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              action_i,
  input  wire logic [7:0]                        in_red_i,
  input  wire logic [7:0]                        in_green_i,
  input  wire logic [7:0]                        in_blue_i,
  input  wire logic [7:0]                        in_alpha_i,
  input  wire logic [7:0]                        in_intensity_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             out_red_o,
  output logic [7:0]                             out_green_o,
  output logic [7:0]                             out_blue_o,
  output logic [7:0]                             out_alpha_o,
  output logic                                   frame_end_o
);

  // configuration
  logic [10:0] cols_q;
  logic [15:0] rows_q;
  logic [3:0]  win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= opmf_pkg::ColsReset;
      rows_q <= opmf_pkg::RowsReset;
      win_q  <= opmf_pkg::WinReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        opmf_pkg::CfgColumns: cols_q <= cfg_data_i[10:0];
        opmf_pkg::CfgRows:    rows_q <= cfg_data_i;
        opmf_pkg::CfgWindow:  win_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [10:0] cols_eff, clast;
  logic [15:0] rows_eff, rlast;
  logic [3:0]  win_eff, half, reach;

  always_comb begin
    if (cols_q == 11'd0)                          cols_eff = 11'd1;
    else if (cols_q > 11'(opmf_pkg::MaxColumns)) cols_eff = 11'(opmf_pkg::MaxColumns);
    else                                          cols_eff = cols_q;
    rows_eff = (rows_q == 16'd0) ? 16'd1 : rows_q;
    win_eff  = (win_q == 4'd0) ? 4'd1 : win_q;
    clast    = cols_eff - 11'd1;
    rlast    = rows_eff - 16'd1;
    half     = win_eff >> 1;
    reach    = win_eff - 4'd1 - half;
  end

  // position counters
  logic [opmf_pkg::ColW-1:0] in_col_q, out_col_q;
  logic [15:0]               in_row_q, out_row_q;
  logic                      in_done_q;
  logic                      wr_pixel;
  logic                      col_wrap_in, row_wrap_in, col_wrap_out, row_wrap_out;

  assign wr_pixel     = cmd_i.accept && !action_i;
  assign col_wrap_in  = ({1'b0, in_col_q} + 11'd1) >= cols_eff;
  assign row_wrap_in  = ({1'b0, in_row_q} + 17'd1) >= {1'b0, rows_eff};
  assign col_wrap_out = ({1'b0, out_col_q} + 11'd1) >= cols_eff;
  assign row_wrap_out = ({1'b0, out_row_q} + 17'd1) >= {1'b0, rows_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_done_q <= 1'b0;
    end else begin
      if (wr_pixel) begin
        in_done_q <= 1'b0;
        if (col_wrap_in) begin
          in_col_q <= '0;
          if (row_wrap_in) begin
            in_row_q  <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 16'd1;
          end
        end else begin
          in_col_q <= in_col_q + 10'd1;
        end
      end
      if (cmd_i.emit) begin
        if (col_wrap_out) begin
          out_col_q <= '0;
          if (row_wrap_out) begin
            out_row_q <= '0;
            in_done_q <= 1'b0;
          end else begin
            out_row_q <= out_row_q + 16'd1;
          end
        end else begin
          out_col_q <= out_col_q + 10'd1;
        end
      end
    end
  end

  // every pixel the window needs has arrived
  logic [16:0] nr_sum;
  logic [10:0] nc_sum;
  logic [15:0] nr;
  logic [10:0] nc;

  always_comb begin
    nr_sum = {1'b0, out_row_q} + {13'd0, reach};
    nc_sum = {1'b0, out_col_q} + {7'd0, reach};
    nr     = (nr_sum > {1'b0, rlast}) ? rlast : nr_sum[15:0];
    nc     = (nc_sum > clast) ? clast : nc_sum;
  end

  assign sts_o.result_ready = in_done_q || (in_row_q > nr) ||
                              ((in_row_q == nr) && ({1'b0, in_col_q} > nc));

  // window scan counters; vr/vc are unclamped signed window positions
  logic [3:0]  u_q, v_q;
  logic [17:0] vr_q;
  logic [11:0] vc_q;
  logic [11:0] vc_start;
  logic        last_u;

  assign vc_start        = {2'b0, out_col_q} - {8'd0, half};
  assign last_u          = (u_q == win_eff - 4'd1);
  assign sts_o.scan_last = last_u && (v_q == win_eff - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q  <= '0;
      v_q  <= '0;
      vr_q <= '0;
      vc_q <= '0;
    end else if (cmd_i.setup) begin
      u_q  <= '0;
      v_q  <= '0;
      vr_q <= {2'b0, out_row_q} - {14'd0, half};
      vc_q <= vc_start;
    end else if (cmd_i.issue) begin
      if (last_u) begin
        u_q  <= '0;
        v_q  <= v_q + 4'd1;
        vr_q <= vr_q + 18'd1;
        vc_q <= vc_start;
      end else begin
        u_q  <= u_q + 4'd1;
        vc_q <= vc_q + 12'd1;
      end
    end
  end

  // clamp to the image edge and form the store address
  logic [15:0]                rr;
  logic [9:0]                 cc;
  logic [opmf_pkg::AddrW-1:0] rd_addr, wr_addr;

  always_comb begin
    if (vr_q[17])                                rr = 16'd0;
    else if (vr_q[16] || (vr_q[15:0] > rlast))   rr = rlast;
    else                                         rr = vr_q[15:0];
    if (vc_q[11])                                cc = 10'd0;
    else if (vc_q[10:0] > clast)                 cc = clast[9:0];
    else                                         cc = vc_q[9:0];
  end

  assign rd_addr = {opmf_pkg::mod15(rr), cc};
  assign wr_addr = {opmf_pkg::mod15(in_row_q), in_col_q};

  // line store: one write or one read per cycle
  logic [opmf_pkg::PixW-1:0] store_q [opmf_pkg::StoreDepth];
  logic [opmf_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_pixel) begin
      store_q[wr_addr] <= {in_intensity_i, in_alpha_i, in_blue_i, in_green_i, in_red_i};
    end
    if (cmd_i.issue) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // histogram stages: read count, then increment and compare
  logic                      s2v_q, s3v_q;
  logic [opmf_pkg::PixW-1:0] e3_q;
  logic [7:0]                cnt_rd_q;
  logic [7:0]                counts_q [opmf_pkg::BinCount];
  logic [opmf_pkg::BinCount-1:0] cvalid_q;
  logic                      fwd_v_q;
  logic [7:0]                fwd_bin_q, fwd_cnt_q;
  logic [7:0]                best_q;
  logic [31:0]               chosen_q;
  logic [7:0]                bin2, bin3, cnt_old, cnt_new;

  assign bin2 = rdata_q[39:32];
  assign bin3 = e3_q[39:32];

  always_comb begin
    if (fwd_v_q && (fwd_bin_q == bin3)) cnt_old = fwd_cnt_q;
    else if (cvalid_q[bin3])            cnt_old = cnt_rd_q;
    else                                cnt_old = 8'd0;
    cnt_new = cnt_old + 8'd1;
  end

  always_ff @(posedge clk_i) begin
    if (s2v_q) begin
      cnt_rd_q <= counts_q[bin2];
      e3_q     <= rdata_q;
    end
    if (s3v_q) begin
      counts_q[bin3] <= cnt_new;
      fwd_bin_q      <= bin3;
      fwd_cnt_q      <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2v_q    <= 1'b0;
      s3v_q    <= 1'b0;
      fwd_v_q  <= 1'b0;
      cvalid_q <= '0;
      best_q   <= '0;
      chosen_q <= '0;
    end else begin
      s2v_q   <= cmd_i.issue;
      s3v_q   <= s2v_q;
      fwd_v_q <= s3v_q;
      if (cmd_i.setup) begin
        cvalid_q <= '0;
        best_q   <= '0;
        chosen_q <= '0;
      end else if (s3v_q) begin
        cvalid_q[bin3] <= 1'b1;
        if (cnt_new > best_q) begin
          best_q   <= cnt_new;
          chosen_q <= e3_q[31:0];
        end
      end
    end
  end

  assign sts_o.pipe_busy = s2v_q || s3v_q;

  // output register
  logic       out_valid_q, fe_q;
  logic [31:0] out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pix_q <= chosen_q;
      fe_q      <= col_wrap_out && row_wrap_out;
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.out_valid = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_pix_q[7:0];
  assign out_green_o     = out_pix_q[15:8];
  assign out_blue_o      = out_pix_q[23:16];
  assign out_alpha_o     = out_pix_q[31:24];
  assign frame_end_o     = fe_q;

endmodule
`default_nettype wire

@@ rtl/oil_paint_mode_filter_top.sv @@
// Oil paint mode filter: top level joining sequencer and datapath.
// Usage:
//  - Input channel (in_valid_i / in_stall_o): action_i = 0 transfers a pixel
//    (RGBA plus intensity) in raster order; action_i = 1 drains one pending
//    result. Each input transfer yields zero or one result.
//  - Output channel (out_valid_o / out_stall_i): one result per transfer,
//    the RGBA of the most frequent intensity in the window; frame_end_o marks
//    the last pixel of a frame.
//  - Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 sets
//    columns, 1 rows, 2 window width. Write only while the block is idle.
//  - Sequence: an input item with no result passes Check and returns to Idle.
//    One with a result goes on through Setup, Scan, Flush and Emit; the window
//    scan reads one line-store entry per cycle, W*W entries (W = window width).
//  - The output register holds a result while out_stall_i is high; the next
//    item is still accepted, and its result waits until the register frees.
//  - Reset clears counters and control; the line store needs no clearing.
`default_nettype none
module oil_paint_mode_filter_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [opmf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [opmf_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              action_i,
  input  wire logic [7:0]                        in_red_i,
  input  wire logic [7:0]                        in_green_i,
  input  wire logic [7:0]                        in_blue_i,
  input  wire logic [7:0]                        in_alpha_i,
  input  wire logic [7:0]                        in_intensity_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [7:0]                             out_red_o,
  output logic [7:0]                             out_green_o,
  output logic [7:0]                             out_blue_o,
  output logic [7:0]                             out_alpha_o,
  output logic                                   frame_end_o
);

  opmf_pkg::ctrl_cmd_t cmd;
  opmf_pkg::dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  opmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  opmf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .in_alpha_i     (in_alpha_i),
    .in_intensity_i (in_intensity_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o),
    .frame_end_o    (frame_end_o)
  );

endmodule
`default_nettype wire
